// ===== sv/utf16_to_utf8_transcoder_assert.svh =====
// Assertion macros used by the transcoder back end.
`ifndef UTF16_TO_UTF8_TRANSCODER_ASSERT_SVH
`define UTF16_TO_UTF8_TRANSCODER_ASSERT_SVH

// Same-cycle implication, off during reset.
`define U16U8_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define U16U8_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/u16u8_pkg.sv =====
package u16u8_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [15:0] CAP_RESET   = 16'd4096;
  localparam logic [15:0] HI_SUR_LO   = 16'hD800;
  localparam logic [15:0] HI_SUR_HI   = 16'hDBFF;
  localparam logic [20:0] LO_SUR_BASE = 21'h00DC00;
  localparam logic [20:0] SUPP_BASE   = 21'h010000;
  localparam logic [20:0] LIM_1BYTE   = 21'h000080;
  localparam logic [20:0] LIM_2BYTE   = 21'h000800;
  localparam logic [20:0] LIM_3BYTE   = 21'h010000;

  // UTF-8 lead and continuation prefixes
  localparam logic [2:0] LEAD2_PFX = 3'b110;
  localparam logic [3:0] LEAD3_PFX = 4'b1110;
  localparam logic [4:0] LEAD4_PFX = 5'b11110;
  localparam logic [1:0] CONT_PFX  = 2'b10;

  // Command from front to back: one code point, its byte count, and
  // whether a terminator follows.
  typedef struct packed {
    logic [20:0] cp;
    logic [2:0]  nbytes;
    logic        term;
  } cmd_t;

endpackage

// ===== sv/u16u8_front.sv =====
module u16u8_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [15:0]     cfg_data,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [15:0]     s_tdata,   // code_unit
  input  logic            s_tlast,   // final_unit
  input  logic            q_full,
  output logic            q_push,
  output u16u8_pkg::cmd_t q_data
);
  import u16u8_pkg::*;

  logic [15:0] byte_capacity;
  logic [15:0] held_high_surrogate;
  logic        high_surrogate_held;
  logic [15:0] bytes_written;
  logic        string_closed;

  logic [15:0] held_high_surrogate_next;
  logic        high_surrogate_held_next;
  logic [15:0] bytes_written_next;
  logic        string_closed_next;

  logic        accept;
  logic        emit;
  logic [20:0] cp;
  logic [2:0]  len;
  logic        terminate;
  logic [16:0] need;

  assign cfg_ready = 1'b1;
  assign s_tready  = !q_full;
  assign accept    = s_tvalid && s_tready;

  // Code point of the word, joined with a held high surrogate if any, and its byte count
  always_comb begin
    if (high_surrogate_held) begin
      cp = SUPP_BASE + {1'b0, held_high_surrogate[9:0], 10'b0} + {5'b0, s_tdata} - LO_SUR_BASE;
    end else begin
      cp = {5'b0, s_tdata};
    end
    if (cp < LIM_1BYTE) begin
      len = 3'd1;
    end else if (cp < LIM_2BYTE) begin
      len = 3'd2;
    end else if (cp < LIM_3BYTE) begin
      len = 3'd3;
    end else begin
      len = 3'd4;
    end
    need = {1'b0, bytes_written} + {14'b0, len};
  end

  // Classify the word and update the string state
  always_comb begin
    held_high_surrogate_next = held_high_surrogate;
    high_surrogate_held_next = high_surrogate_held;
    bytes_written_next       = bytes_written;
    string_closed_next       = string_closed;
    emit                     = 1'b0;
    terminate                = 1'b0;
    q_data.cp                = cp;
    q_data.nbytes            = 3'd0;
    q_data.term              = 1'b0;
    if (string_closed) begin
      // drop words up to and including the final one; a fresh string starts after it
      if (s_tlast) begin
        string_closed_next = 1'b0;
        bytes_written_next = 16'd0;
      end
    end else if (!high_surrogate_held && (s_tdata inside {[HI_SUR_LO:HI_SUR_HI]}) &&
                 !s_tlast) begin
      held_high_surrogate_next = s_tdata;
      high_surrogate_held_next = 1'b1;
    end else begin
      high_surrogate_held_next = 1'b0;
      held_high_surrogate_next = 16'd0;
      if (!high_surrogate_held && s_tdata == 16'd0) begin
        terminate = 1'b1;
      end else if (need >= {1'b0, byte_capacity}) begin
        terminate = 1'b1;
      end else begin
        q_data.nbytes      = len;
        bytes_written_next = need[15:0];
      end
      q_data.term = terminate || s_tlast;
      emit        = 1'b1;
      if (q_data.term) begin
        string_closed_next = 1'b1;
      end
      if (s_tlast) begin
        held_high_surrogate_next = 16'd0;
        high_surrogate_held_next = 1'b0;
        bytes_written_next       = 16'd0;
        string_closed_next       = 1'b0;
      end
    end
  end

  assign q_push = accept && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_capacity       <= CAP_RESET;
      held_high_surrogate <= 16'd0;
      high_surrogate_held <= 1'b0;
      bytes_written       <= 16'd0;
      string_closed       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        byte_capacity <= cfg_data;
      end
      if (accept) begin
        held_high_surrogate <= held_high_surrogate_next;
        high_surrogate_held <= high_surrogate_held_next;
        bytes_written       <= bytes_written_next;
        string_closed       <= string_closed_next;
      end
    end
  end

endmodule

// ===== sv/u16u8_fifo.sv =====
module u16u8_fifo #(
  parameter int unsigned DEPTH = u16u8_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  u16u8_pkg::cmd_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output u16u8_pkg::cmd_t pop_data
);
  import u16u8_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full     = (count == CW'(DEPTH));
  assign valid    = (count != '0);
  assign pop_data = mem[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  // Store the entry
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== sv/u16u8_back.sv =====
`include "utf16_to_utf8_transcoder_assert.svh"

module u16u8_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  u16u8_pkg::cmd_t q_data,
  output logic            q_pop,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [7:0]      m_tdata,   // out_byte
  output logic            m_tuser,   // is_terminator
  output logic            m_tlast    // last_of_item
);
  import u16u8_pkg::*;

  cmd_t       cur;
  logic       cur_valid;
  logic [2:0] pos;

  logic       out_free;
  logic       emit;
  logic       take;
  logic [2:0] total;
  logic       is_last;
  logic       is_term;
  logic [1:0] cont_sel;
  logic [7:0] byte_val;

  assign out_free = !m_tvalid || m_tready;
  assign emit     = cur_valid && out_free;
  assign total    = cur.nbytes + {2'b0, cur.term};
  assign is_last  = (pos == total - 3'd1);
  assign is_term  = (pos == cur.nbytes);
  assign take     = !cur_valid || (emit && is_last);
  assign q_pop    = take && q_valid;
  assign cont_sel = 2'(cur.nbytes - pos - 3'd1);

  // Pick the byte at the current position
  always_comb begin
    byte_val = 8'd0;
    if (is_term) begin
      byte_val = 8'd0;
    end else if (pos == 3'd0) begin
      case (cur.nbytes)
        3'd1:    byte_val = {1'b0, cur.cp[6:0]};
        3'd2:    byte_val = {LEAD2_PFX, cur.cp[10:6]};
        3'd3:    byte_val = {LEAD3_PFX, cur.cp[15:12]};
        default: byte_val = {LEAD4_PFX, cur.cp[20:18]};
      endcase
    end else begin
      case (cont_sel)
        2'd0:    byte_val = {CONT_PFX, cur.cp[5:0]};
        2'd1:    byte_val = {CONT_PFX, cur.cp[11:6]};
        default: byte_val = {CONT_PFX, cur.cp[17:12]};
      endcase
    end
  end

  // Hold the current command and walk its bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      pos       <= 3'd0;
    end else if (take) begin
      cur_valid <= q_valid;
      pos       <= 3'd0;
    end else if (emit) begin
      pos <= pos + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur <= q_data;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= cur_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= byte_val;
      m_tuser <= is_term;
      m_tlast <= is_last;
    end
  end

  `U16U8_ASSERT_NOW(a_term_is_last, m_tvalid && m_tuser, m_tlast, "terminator not last of word")
  `U16U8_ASSERT_NOW(a_pos_in_range, cur_valid, pos < total, "byte position past command")
  `U16U8_ASSERT_NEXT(a_cont_prefix, emit && pos != 3'd0 && pos < cur.nbytes,
                     m_tdata[7:6] == CONT_PFX, "continuation byte without 10 prefix")

endmodule

// ===== sv/utf16_to_utf8_transcoder.sv =====
// A word's first byte passes the command queue, the back end's command register and
// the output register on its way to m_tdata. Throughput: one word per cycle while the
// command queue has room; the back end sends one byte per cycle unless m_tready is low;
// a word yields 0 to 5 bytes with terminator; the byte-wide output register sets the rate.
// Reset (rst, synchronous): queue, string state and output valid clear; capacity is 4096.
module utf16_to_utf8_transcoder #(
  parameter int unsigned QDEPTH = u16u8_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,   // byte_capacity
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,    // code_unit
  input  logic        s_tlast,    // final_unit
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,    // out_byte
  output logic        m_tuser,    // is_terminator
  output logic        m_tlast     // last_of_item
);
  import u16u8_pkg::*;

  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_valid;
  cmd_t q_in;
  cmd_t q_out;

  u16u8_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_in)
  );

  u16u8_fifo #(
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_out)
  );

  u16u8_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_data   (q_out),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// ===== sim/tb_utf16_to_utf8_transcoder.sv =====
module tb_utf16_to_utf8_transcoder;
  timeunit 1ns;
  timeprecision 1ps;

  import u16u8_pkg::*;

  localparam int unsigned RESET_CYCLES    = 11;
  localparam int unsigned DRAIN_CYCLES    = 12;
  localparam int unsigned TAIL_CYCLES     = 20;
  localparam int unsigned HOLD_OFF_CYCLES = 250;
  localparam int unsigned QUIET_LIMIT     = 3000;
  localparam int unsigned REPORT_LIMIT    = 10;

  // Directed words: bit 16 marks the final unit of a string.
  localparam int unsigned DIRECTED_COUNT = 25;
  localparam logic [16:0] DIRECTED_UNITS [DIRECTED_COUNT] = '{
    // one to three byte boundaries, then valid pairs
    17'h0_0041, 17'h0_007F, 17'h0_0080, 17'h0_07FF, 17'h0_0800, 17'h0_FFFF,
    17'h0_D83D, 17'h0_DE00, 17'h0_DBFF, 17'h0_DFFF, 17'h0_D800, 17'h0_DC00,
    17'h1_0001,
    // zero follower, largest unchecked pair, lone low, high surrogate as final
    17'h0_D800, 17'h0_0000, 17'h0_DBFF, 17'h0_FFFF, 17'h0_DC00, 17'h1_DABC,
    // zero ends the string, then words are dropped up to the final one
    17'h0_0042, 17'h0_0000, 17'h0_0043, 17'h0_D800, 17'h1_0044,
    // string made of a single final zero
    17'h1_0000
  };

  // Predicts the UTF-8 bytes of each accepted code unit and checks the output.
  class utf8_byte_checker;
    typedef struct packed {
      logic [7:0] data;
      logic       term;
      logic       last;
    } utf8_byte_t;

    utf8_byte_t  expected_bytes[$];
    logic [15:0] capacity;
    logic [15:0] held_unit;
    bit          held;
    logic [15:0] written;
    bit          closed;
    int unsigned mismatches;

    function new();
      capacity   = CAP_RESET;
      mismatches = 0;
      clear_string();
    endfunction

    function void clear_string();
      held_unit = '0;
      held      = 1'b0;
      written   = '0;
      closed    = 1'b0;
    endfunction

    function void set_capacity(logic [15:0] cap);
      capacity = cap;
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction

    function void push_byte(logic [7:0] data, logic term);
      utf8_byte_t b;
      b.data = data;
      b.term = term;
      b.last = 1'b0;
      expected_bytes.push_back(b);
    endfunction

    function void note_unit(logic [15:0] unit, bit fin);
      int unsigned cp;
      int unsigned len;
      int unsigned n_before;
      bit          term;
      term     = 1'b0;
      n_before = expected_bytes.size();
      // drop words after the terminator; a final one reopens the string
      if (closed) begin
        if (fin) clear_string();
        return;
      end
      cp = 32'(unit);
      if (held) begin
        // combine with whatever follows, no low surrogate check
        cp = 32'h10000 + ((32'(held_unit) - 32'hD800) << 10) + 32'(unit) - 32'hDC00;
        held      = 1'b0;
        held_unit = '0;
      end else if (unit == 16'h0000) begin
        term = 1'b1;
      end else if (unit >= HI_SUR_LO && unit <= HI_SUR_HI && !fin) begin
        held_unit = unit;
        held      = 1'b1;
        return;
      end
      if (!term) begin
        len = (cp < 32'(LIM_1BYTE)) ? 1 : (cp < 32'(LIM_2BYTE)) ? 2 :
              (cp < 32'(LIM_3BYTE)) ? 3 : 4;
        // the character and a terminator must both fit
        if (32'(written) + len >= 32'(capacity)) begin
          term = 1'b1;
        end else begin
          case (len)
            1: push_byte(8'(cp), 1'b0);
            2: begin
              push_byte(8'(32'hC0 | (cp >> 6)), 1'b0);
              push_byte(8'(32'h80 | (cp & 32'h3F)), 1'b0);
            end
            3: begin
              push_byte(8'(32'hE0 | (cp >> 12)), 1'b0);
              push_byte(8'(32'h80 | ((cp >> 6) & 32'h3F)), 1'b0);
              push_byte(8'(32'h80 | (cp & 32'h3F)), 1'b0);
            end
            default: begin
              push_byte(8'(32'hF0 | (cp >> 18)), 1'b0);
              push_byte(8'(32'h80 | ((cp >> 12) & 32'h3F)), 1'b0);
              push_byte(8'(32'h80 | ((cp >> 6) & 32'h3F)), 1'b0);
              push_byte(8'(32'h80 | (cp & 32'h3F)), 1'b0);
            end
          endcase
          written = written + 16'(len);
        end
      end
      if (term || fin) begin
        push_byte(8'h00, 1'b1);
        closed = 1'b1;
      end
      if (fin) clear_string();
      // flag the final byte caused by this word
      if (expected_bytes.size() > n_before)
        expected_bytes[expected_bytes.size() - 1].last = 1'b1;
    endfunction

    function void check_byte(logic [7:0] data, logic term, logic last);
      utf8_byte_t want;
      if (expected_bytes.size() == 0) begin
        if (mismatches < REPORT_LIMIT)
          $display("unexpected byte %02h term %0b last %0b at %0t", data, term, last, $time);
        mismatches++;
        return;
      end
      want = expected_bytes.pop_front();
      if (want.data !== data || want.term !== term || want.last !== last) begin
        if (mismatches < REPORT_LIMIT)
          $display("mismatch at %0t: expected byte %02h term %0b last %0b, got %02h %0b %0b",
                   $time, want.data, want.term, want.last, data, term, last);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst       = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data  = '0;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata   = '0;
  logic        s_tlast   = 1'b0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  utf8_byte_checker checker_h = new();
  bit          bursts_on    = 1'b1;
  bit          hold_off_req = 1'b0;
  int unsigned quiet_cycles = 0;

  utf16_to_utf8_transcoder dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Check every byte word taken from the output.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      checker_h.check_byte(m_tdata, m_tuser, m_tlast);
  end

  // End the run if no handshake of any kind happens for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Output side: ready with random stall bursts and one long hold-off on request.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
      end else if (bursts_on && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 7) - 1) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Offer one code unit, wait for it to be taken, and note it. Returns at a falling edge.
  task automatic send_unit(input logic [15:0] unit, input bit fin);
    if (bursts_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= unit;
    s_tlast  <= fin;
    do @(posedge clk); while (!s_tready);
    checker_h.note_unit(unit, fin);
    @(negedge clk);
  endtask

  // Random strings, mostly well-formed text with pairs, some zeros and broken pairs.
  // Stop after n_units words, possibly in the middle of a string.
  task automatic send_random_run(input int unsigned n_units);
    int unsigned sent;
    int unsigned str_len;
    int unsigned pos;
    int unsigned kind;
    logic [15:0] unit;
    bit          fin;
    sent = 0;
    while (sent < n_units) begin
      str_len = $urandom_range(1, 10);
      pos     = 0;
      while (pos < str_len && sent < n_units) begin
        fin  = (pos == str_len - 1);
        kind = $urandom_range(0, 99);
        if (kind < 25) begin
          unit = 16'($urandom_range(1, 16'h007F));
        end else if (kind < 40) begin
          unit = 16'($urandom_range(16'h0080, 16'h07FF));
        end else if (kind < 55) begin
          unit = 16'($urandom_range(16'h0800, 16'hFFFF));
        end else if (kind < 78) begin
          // surrogate pair; the follower is a low surrogate or anything at all
          send_unit(16'($urandom_range(HI_SUR_LO, HI_SUR_HI)), 1'b0);
          sent++;
          if (kind < 70)
            unit = 16'($urandom_range(16'hDC00, 16'hDFFF));
          else
            unit = 16'($urandom_range(0, 16'hFFFF));
        end else if (kind < 83) begin
          unit = 16'h0000;
        end else if (kind < 88) begin
          unit = 16'($urandom_range(HI_SUR_LO, HI_SUR_HI));
        end else begin
          unit = 16'($urandom_range(0, 16'hFFFF));
        end
        send_unit(unit, fin);
        sent++;
        pos++;
      end
    end
    s_tvalid <= 1'b0;
  endtask

  // Write the capacity once all bytes are out and any held word has settled.
  task automatic write_capacity(input logic [15:0] cap);
    while (checker_h.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk); while (!cfg_ready);
    checker_h.set_capacity(cap);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_capacity(CAP_RESET);
    foreach (DIRECTED_UNITS[i])
      send_unit(DIRECTED_UNITS[i][15:0], DIRECTED_UNITS[i][16]);
    s_tvalid <= 1'b0;

    // zero capacity: the first character yields only the terminator
    write_capacity(16'd0);
    send_unit(16'h0041, 1'b0);
    send_unit(16'h00E9, 1'b1);
    send_random_run(12);

    write_capacity(16'd1);
    send_random_run(15);

    // largest capacity, with a long output hold-off to fill the block
    write_capacity(16'hFFFF);
    hold_off_req = 1'b1;
    send_random_run(120);

    // small capacities hit the limit often; alternate idling on and off
    for (int i = 0; i < 4; i++) begin
      write_capacity(16'($urandom_range(2, 12)));
      bursts_on = (i % 2 == 0);
      send_random_run(20);
    end

    bursts_on = 1'b1;
    write_capacity(16'($urandom_range(1, 16'hFFFF)));
    send_random_run(60);

    // closing stretch at full rate
    bursts_on = 1'b0;
    write_capacity(16'd2048);
    send_random_run(120);

    while (checker_h.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (checker_h.mismatches == 0 && checker_h.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
